// ----- design/php_pkg.sv -----
// ----------------------------------------------------------------------------
// php_pkg
// Shared types and constants for the point hit test scan unit.
// ----------------------------------------------------------------------------
package php_pkg;

  localparam int COORD_BITS = 24;
  localparam int DW         = COORD_BITS + 1;
  localparam int PW         = 2 * DW;
  localparam int TASK_DEPTH = 4;
  localparam int RES_DEPTH  = 2;

  localparam logic OP_VERTEX = 1'b0;
  localparam logic OP_CIRCLE = 1'b1;

  typedef struct packed {
    logic                         op;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic        [COORD_BITS-2:0] radius;
    logic                         last_in_object;
    logic                         last_in_scene;
  } in_t;

  typedef struct packed {
    logic       hit_found;
    logic [7:0] selected_index;
  } out_t;

  typedef logic signed [DW-1:0] opnd_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef struct packed {
    logic  en;
    opnd_t a;
    opnd_t b;
    opnd_t c;
    opnd_t d;
  } lane_t;

  typedef struct packed {
    logic  is_circle;
    logic  start;
    logic  last_obj;
    logic  last_scene;
    lane_t lane_a;
    lane_t lane_b;
  } task_t;

endpackage

// ----- design/php_fifo.sv -----
// ----------------------------------------------------------------------------
// php_fifo
// Small register queue with a combinational head.
// ----------------------------------------------------------------------------
module php_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    rd_ptr;
  logic [AW-1:0]    wr_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- design/php_front.sv -----
// ----------------------------------------------------------------------------
// php_front
// Accepts items, tracks the open polygon and forms the edge and disc
// operands for the back end.
// ----------------------------------------------------------------------------
module php_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  logic                                  q_full,
  input  php_pkg::in_t                          item,
  input  logic signed [php_pkg::COORD_BITS-1:0] query_x,
  input  logic signed [php_pkg::COORD_BITS-1:0] query_y,
  output logic                                  task_push,
  output php_pkg::task_t                        task_out
);

  logic signed [php_pkg::COORD_BITS-1:0] first_x;
  logic signed [php_pkg::COORD_BITS-1:0] first_y;
  logic signed [php_pkg::COORD_BITS-1:0] prev_x;
  logic signed [php_pkg::COORD_BITS-1:0] prev_y;
  logic                                  poly_open;
  logic                                  accept;
  logic                                  is_circle;
  logic signed [php_pkg::COORD_BITS-1:0] close_x;
  logic signed [php_pkg::COORD_BITS-1:0] close_y;
  php_pkg::lane_t                        edge_a;
  php_pkg::lane_t                        edge_b;
  php_pkg::lane_t                        disc_a;
  php_pkg::lane_t                        disc_b;

  function automatic php_pkg::opnd_t ext(input logic signed [php_pkg::COORD_BITS-1:0] v);
    return php_pkg::DW'(v);
  endfunction

  function automatic php_pkg::lane_t edge_ops(
    input logic signed [php_pkg::COORD_BITS-1:0] ax,
    input logic signed [php_pkg::COORD_BITS-1:0] ay,
    input logic signed [php_pkg::COORD_BITS-1:0] bx,
    input logic signed [php_pkg::COORD_BITS-1:0] by,
    input logic signed [php_pkg::COORD_BITS-1:0] qx,
    input logic signed [php_pkg::COORD_BITS-1:0] qy
  );
    php_pkg::lane_t r;
    php_pkg::opnd_t dy;
    php_pkg::opnd_t qxa;
    php_pkg::opnd_t qya;
    php_pkg::opnd_t bxa;
    dy   = ext(by) - ext(ay);
    qxa  = ext(qx) - ext(ax);
    qya  = ext(qy) - ext(ay);
    bxa  = ext(bx) - ext(ax);
    r.en = ((qy < ay) != (qy < by));
    if (dy > 0) begin
      r.a = qxa;
      r.b = dy;
      r.c = qya;
      r.d = bxa;
    end else begin
      r.a = qya;
      r.b = bxa;
      r.c = qxa;
      r.d = dy;
    end
    return r;
  endfunction

  assign accept    = push && !q_full;
  assign is_circle = (item.op == php_pkg::OP_CIRCLE);
  assign close_x   = poly_open ? first_x : item.point_x;
  assign close_y   = poly_open ? first_y : item.point_y;

  always_comb begin
    edge_a    = edge_ops(prev_x, prev_y, item.point_x, item.point_y, query_x, query_y);
    edge_a.en = edge_a.en && poly_open;
    edge_b    = edge_ops(item.point_x, item.point_y, close_x, close_y, query_x, query_y);
    edge_b.en = edge_b.en && item.last_in_object;

    disc_a.en = 1'b0;
    disc_a.a  = ext(query_x) - ext(item.point_x);
    disc_a.b  = disc_a.a;
    disc_a.c  = ext(query_y) - ext(item.point_y);
    disc_a.d  = disc_a.c;
    disc_b.en = 1'b0;
    disc_b.a  = php_pkg::DW'(item.radius);
    disc_b.b  = disc_b.a;
    disc_b.c  = '0;
    disc_b.d  = '0;

    task_out.is_circle  = is_circle;
    task_out.start      = !poly_open;
    task_out.last_obj   = item.last_in_object;
    task_out.last_scene = item.last_in_scene;
    task_out.lane_a     = is_circle ? disc_a : edge_a;
    task_out.lane_b     = is_circle ? disc_b : edge_b;
  end

  assign task_push = accept;

  always_ff @(posedge clk) begin
    if (accept && !is_circle) begin
      prev_x <= item.point_x;
      prev_y <= item.point_y;
      if (!poly_open) begin
        first_x <= item.point_x;
        first_y <= item.point_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_open <= 1'b0;
    end else if (accept) begin
      if (is_circle || item.last_in_scene) begin
        poly_open <= 1'b0;
      end else begin
        poly_open <= !item.last_in_object;
      end
    end
  end

endmodule

// ----- design/php_back.sv -----
// ----------------------------------------------------------------------------
// php_back
// Multiplies the operands of each queued task, resolves crossings and disc
// hits, keeps parity and the first hit, and queues the scene result.
// ----------------------------------------------------------------------------
module php_back #(
  parameter int MAX_OBJECTS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  php_pkg::task_t q_head,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic           pop,
  output logic           empty,
  output php_pkg::out_t  result
);

  localparam int CNT_W = (MAX_OBJECTS > 2) ? $clog2(MAX_OBJECTS) : 1;
  localparam int IDX_W = (CNT_W > 8) ? CNT_W : 8;

  typedef struct packed {
    logic           is_circle;
    logic           start;
    logic           last_obj;
    logic           last_scene;
    logic           en_a;
    logic           en_b;
    php_pkg::prod_t a_ab;
    php_pkg::prod_t a_cd;
    php_pkg::prod_t b_ab;
    php_pkg::prod_t b_cd;
  } stage_t;

  stage_t                      s1;
  logic                        s1_valid;
  logic                        advance;
  logic                        res_full;
  logic                        res_push;
  php_pkg::out_t               res_data;
  logic [$bits(php_pkg::out_t)-1:0] res_rdata;

  logic                        parity;
  logic [CNT_W-1:0]            counter;
  logic                        latched;
  logic [CNT_W-1:0]            hit_index;

  logic                        cross_a;
  logic                        cross_b;
  logic signed [php_pkg::PW:0] d2;
  logic                        disc_hit;
  logic                        poly_par;
  logic                        obj_done;
  logic                        obj_hit;
  logic                        parity_next;
  logic                        latched_next;
  logic [CNT_W-1:0]            hit_index_next;
  logic [CNT_W-1:0]            counter_next;
  logic [IDX_W-1:0]            idx_wide;

  function automatic php_pkg::prod_t mul(input php_pkg::opnd_t x, input php_pkg::opnd_t y);
    php_pkg::prod_t xe;
    php_pkg::prod_t ye;
    xe = php_pkg::PW'(x);
    ye = php_pkg::PW'(y);
    return xe * ye;
  endfunction

  assign advance = !s1_valid || !s1.last_scene || !res_full;
  assign q_pop   = advance && !q_empty;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1.is_circle  <= q_head.is_circle;
      s1.start      <= q_head.start;
      s1.last_obj   <= q_head.last_obj;
      s1.last_scene <= q_head.last_scene;
      s1.en_a       <= q_head.lane_a.en;
      s1.en_b       <= q_head.lane_b.en;
      s1.a_ab       <= mul(q_head.lane_a.a, q_head.lane_a.b);
      s1.a_cd       <= mul(q_head.lane_a.c, q_head.lane_a.d);
      s1.b_ab       <= mul(q_head.lane_b.a, q_head.lane_b.b);
      s1.b_cd       <= mul(q_head.lane_b.c, q_head.lane_b.d);
    end
  end

  always_comb begin
    cross_a  = s1.en_a && (s1.a_ab < s1.a_cd);
    cross_b  = s1.en_b && (s1.b_ab < s1.b_cd);
    d2       = (php_pkg::PW + 1)'(s1.a_ab) + (php_pkg::PW + 1)'(s1.a_cd);
    disc_hit = !((php_pkg::PW + 1)'(s1.b_ab) < d2);
    poly_par = (parity && !s1.start) ^ cross_a ^ cross_b;

    if (s1.is_circle) begin
      obj_done    = 1'b1;
      obj_hit     = disc_hit;
      parity_next = 1'b0;
    end else if (s1.last_obj) begin
      obj_done    = 1'b1;
      obj_hit     = poly_par;
      parity_next = 1'b0;
    end else begin
      obj_done    = 1'b0;
      obj_hit     = 1'b0;
      parity_next = poly_par;
    end

    latched_next   = latched || (obj_done && obj_hit);
    hit_index_next = (obj_done && obj_hit && !latched) ? counter : hit_index;
    if (!obj_done) begin
      counter_next = counter;
    end else if (counter == CNT_W'(MAX_OBJECTS - 1)) begin
      counter_next = '0;
    end else begin
      counter_next = counter + CNT_W'(1);
    end

    idx_wide                = IDX_W'(hit_index_next);
    res_data.hit_found      = latched_next;
    res_data.selected_index = latched_next ? idx_wide[7:0] : 8'd0;
    res_push                = s1_valid && s1.last_scene && !res_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      parity    <= 1'b0;
      counter   <= '0;
      latched   <= 1'b0;
      hit_index <= '0;
    end else begin
      if (advance) begin
        s1_valid <= q_pop;
      end
      if (s1_valid && advance) begin
        if (s1.last_scene) begin
          parity    <= 1'b0;
          counter   <= '0;
          latched   <= 1'b0;
          hit_index <= '0;
        end else begin
          parity    <= parity_next;
          counter   <= counter_next;
          latched   <= latched_next;
          hit_index <= hit_index_next;
        end
      end
    end
  end

  php_fifo #(
    .WIDTH ($bits(php_pkg::out_t)),
    .DEPTH (php_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = res_rdata;

endmodule

// ----- design/point_hit_test_scan_unit.sv -----
// ----------------------------------------------------------------------------
// point_hit_test_scan_unit
// Finds the first scene object (polygon or circle) that holds a query point.
//
// Set query_x and query_y over the APB port (byte addresses 0 and 4) while
// the unit is idle. Push scene items in scan order on the input queue: a
// polygon as its vertices with last_in_object on the final one, a circle as
// one item. Each item is accepted when push is high and full is low; one item
// a cycle is taken without a break while the back end keeps up.
// Each edge test takes two products and the disc test three, all in the
// back end's single multiply stage.
// On the item marked last_in_scene one result appears on the output queue:
// hit_found and the index of the first containing object. The item passes
// through the task queue and the multiply stage and its result through the
// result queue before the result can be popped. Holding pop low stalls the
// back end only when a result cannot be queued; the task queue between front
// and back then fills and full rises. Reset empties both queues, closes any
// open polygon and clears the scan state and the query registers.
// ----------------------------------------------------------------------------
module point_hit_test_scan_unit #(
  parameter int MAX_OBJECTS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          push,
  output logic          full,
  input  php_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output php_pkg::out_t result
);

  localparam logic REG_QUERY_X = 1'b0;
  localparam logic REG_QUERY_Y = 1'b1;

  logic signed [php_pkg::COORD_BITS-1:0] query_x;
  logic signed [php_pkg::COORD_BITS-1:0] query_y;
  logic                                  cfg_write;

  logic                                  task_push;
  php_pkg::task_t                        task_in;
  logic [$bits(php_pkg::task_t)-1:0]     task_rdata;
  php_pkg::task_t                        task_head;
  logic                                  q_full;
  logic                                  q_empty;
  logic                                  q_pop;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_QUERY_X: query_x <= pwdata[php_pkg::COORD_BITS-1:0];
        REG_QUERY_Y: query_y <= pwdata[php_pkg::COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_QUERY_X: prdata = 32'(unsigned'(query_x));
      REG_QUERY_Y: prdata = 32'(unsigned'(query_y));
      default:     prdata = '0;
    endcase
  end

  assign full = q_full;

  php_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .q_full    (q_full),
    .item      (item),
    .query_x   (query_x),
    .query_y   (query_y),
    .task_push (task_push),
    .task_out  (task_in)
  );

  php_fifo #(
    .WIDTH ($bits(php_pkg::task_t)),
    .DEPTH (php_pkg::TASK_DEPTH)
  ) u_task_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (task_push),
    .wdata (task_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (task_rdata),
    .empty (q_empty)
  );

  assign task_head = task_rdata;

  php_back #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_head  (task_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule
